@@ design/b64o_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character constants and the base64 alphabet function.
package b64o_pkg;

   localparam int unsigned HDR_LEN   = 7;
   localparam int unsigned BURST_MAX = 8;

   localparam logic [7:0] BEL_CHAR = 8'h07;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // ESC ] 5 2 ; c ; with the first character in entry 0
   localparam logic [HDR_LEN-1:0][7:0] HDR_TEXT = {
      8'h3B, 8'h63, 8'h3B, 8'h32, 8'h35, 8'h5D, 8'h1B
   };

   // Characters caused by one request, first in entry 0
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] chars;
      logic [3:0]                count;
   } burst_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = w + 8'd65;
      end else if (v < 6'd52) begin
         c = w + 8'd71;
      end else if (v < 6'd62) begin
         c = w - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

@@ design/b64o_encoder.sv @@
`timescale 1ns / 1ps
// Message state and the character burst produced by each request.
module b64o_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                end_of_message,
   output b64o_pkg::burst_type burst
);
   import b64o_pkg::*;

   logic [15:0] pending_bytes_ff, pending_bytes_in;
   logic [1:0]  pending_count_ff, pending_count_in;
   logic        header_sent_ff, header_sent_in;

   logic [7:0] b0, b1;
   logic [7:0] c0, c1, c2_tail, c2_full, c3_full;

   assign b0 = pending_bytes_ff[15:8];
   assign b1 = pending_bytes_ff[7:0];

   assign c0      = b64_char(b0[7:2]);
   assign c1      = b64_char({b0[1:0], b1[7:4]});
   assign c2_tail = b64_char({b1[3:0], 2'b00});
   assign c2_full = b64_char({b1[3:0], data_byte[7:6]});
   assign c3_full = b64_char(data_byte[5:0]);

   always_comb begin
      burst.chars = '0;
      burst.count = 4'd0;
      if (!header_sent_ff) begin
         // pending count is zero here, so only BEL can follow the header
         for (int i = 0; i < HDR_LEN; i++) begin
            burst.chars[i] = HDR_TEXT[i];
         end
         burst.chars[HDR_LEN] = BEL_CHAR;
         burst.count = end_of_message ? 4'd8 : 4'd7;
      end else if (end_of_message) begin
         case (pending_count_ff)
            2'd1: begin
               burst.chars[0] = c0;
               burst.chars[1] = b64_char({b0[1:0], 4'b0000});
               burst.chars[2] = PAD_CHAR;
               burst.chars[3] = PAD_CHAR;
               burst.chars[4] = BEL_CHAR;
               burst.count    = 4'd5;
            end
            2'd2: begin
               burst.chars[0] = c0;
               burst.chars[1] = c1;
               burst.chars[2] = c2_tail;
               burst.chars[3] = PAD_CHAR;
               burst.chars[4] = BEL_CHAR;
               burst.count    = 4'd5;
            end
            default: begin
               burst.chars[0] = BEL_CHAR;
               burst.count    = 4'd1;
            end
         endcase
      end else if (pending_count_ff == 2'd2) begin
         burst.chars[0] = c0;
         burst.chars[1] = c1;
         burst.chars[2] = c2_full;
         burst.chars[3] = c3_full;
         burst.count    = 4'd4;
      end
   end

   always_comb begin
      pending_bytes_in = pending_bytes_ff;
      pending_count_in = pending_count_ff;
      header_sent_in   = header_sent_ff;
      if (take) begin
         header_sent_in = 1'b1;
         if (end_of_message) begin
            pending_bytes_in = '0;
            pending_count_in = 2'd0;
            header_sent_in   = 1'b0;
         end else begin
            case (pending_count_ff)
               2'd0: begin
                  pending_bytes_in = {data_byte, 8'h00};
                  pending_count_in = 2'd1;
               end
               2'd1: begin
                  pending_bytes_in = {b0, data_byte};
                  pending_count_in = 2'd2;
               end
               default: begin
                  pending_bytes_in = '0;
                  pending_count_in = 2'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bytes_ff <= '0;
         pending_count_ff <= 2'd0;
         header_sent_ff   <= 1'b0;
      end else begin
         pending_bytes_ff <= pending_bytes_in;
         pending_count_ff <= pending_count_in;
         header_sent_ff   <= header_sent_in;
      end
   end

endmodule

@@ design/base64_osc52_encoder_top.sv @@
`timescale 1ns / 1ps
// Top level: OSC 52 base64 encoder with a character serializer.
//
// Requests arrive on req_*: req_tdata carries one message byte, req_tlast
// marks the end of a message (the byte is then ignored). Responses leave on
// rsp_* one character per cycle while rsp_tready is high; rsp_tlast marks
// the last character caused by one request. The first request of a message
// emits the header ESC ] 5 2 ; c ;, every third byte emits four base64
// characters, and the end marker emits the padded tail and BEL.
// A request that causes characters loads an eight-entry burst buffer at
// its accept edge; the first character is visible the next cycle. The
// buffer drains at one character per cycle while the receiver is ready;
// a request causes 1 to 8 characters, and one that causes none loads
// nothing. A new request is taken in the cycle the last character of the
// previous burst is taken, so bursts follow back to back. Sustained
// throughput is set by the single-character output port: of every three
// bytes, two emit nothing and the third emits four characters. When the
// receiver stalls, the current character holds and requests wait. Reset
// clears the message state and empties the buffer.
module base64_osc52_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // run_last
);
   import b64o_pkg::*;

   burst_type burst;

   logic [BURST_MAX-1:0][7:0] chars_ff, chars_in;
   logic [3:0] len_ff, len_in;
   logic [2:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;

   logic last_char, fire_out, done, accept;

   assign last_char  = ({1'b0, idx_ff} == (len_ff - 4'd1));
   assign fire_out   = busy_ff && rsp_tready;
   assign done       = fire_out && last_char;
   assign req_tready = !busy_ff || done;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = chars_ff[idx_ff];
   assign rsp_tlast  = last_char;

   b64o_encoder u_encoder (
      .clock          (clock),
      .reset          (reset),
      .take           (accept),
      .data_byte      (req_tdata),
      .end_of_message (req_tlast),
      .burst          (burst)
   );

   always_comb begin
      chars_in = chars_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (accept && (burst.count != 4'd0)) begin
         chars_in = burst.chars;
         len_in   = burst.count;
         idx_in   = 3'd0;
         busy_in  = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire_out) begin
         // advance to the next character of the burst
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      len_ff   <= len_in;
      if (reset) begin
         idx_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule
